[rtl/eqma_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqma_pkg: shared types, constants and helpers
// Angle format, CORDIC arctangent table, mount kinds and register indexes.
// ----------------------------------------------------------------------------
package eqma_pkg;

  localparam int AngleWidth = 32;
  localparam int Stages     = 30;
  // Datapath width for CORDIC x/y/z; values stay well inside 36 bits.
  localparam int DataWidth  = 36;

  localparam logic signed [DataWidth-1:0] GainComp = 36'sd652032874;
  localparam logic signed [DataWidth-1:0] Quarter  = 36'sd1073741824;
  localparam logic signed [DataWidth-1:0] Half     = 36'sd2147483648;
  localparam logic signed [DataWidth-1:0] PoleTol  = 36'sd331;

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic signed [AngleWidth-1:0] angle_t;

  typedef enum logic [1:0] {
    KIND_GERMAN  = 2'd0,
    KIND_FORK    = 2'd1,
    KIND_ALTAZ   = 2'd2,
    KIND_ALTALT  = 2'd3
  } mount_kind_e;

  typedef enum logic [0:0] {
    REG_LATITUDE = 1'b0,
    REG_KIND     = 1'b1
  } reg_index_e;

  localparam int RegIdxWidth = 1;
  localparam int CfgWidth    = 32;

  typedef enum logic [0:0] {
    MODE_ROTATE = 1'b0,
    MODE_VECTOR = 1'b1
  } cordic_mode_e;

  function automatic data_t atan_entry(input int i);
    data_t t;
    case (i)
      0:  t = 36'sd536870912;
      1:  t = 36'sd316933406;
      2:  t = 36'sd167458907;
      3:  t = 36'sd85004756;
      4:  t = 36'sd42667331;
      5:  t = 36'sd21354465;
      6:  t = 36'sd10679838;
      7:  t = 36'sd5340245;
      8:  t = 36'sd2670163;
      9:  t = 36'sd1335087;
      10: t = 36'sd667544;
      11: t = 36'sd333772;
      12: t = 36'sd166886;
      13: t = 36'sd83443;
      14: t = 36'sd41722;
      15: t = 36'sd20861;
      16: t = 36'sd10430;
      17: t = 36'sd5215;
      18: t = 36'sd2608;
      19: t = 36'sd1304;
      20: t = 36'sd652;
      21: t = 36'sd326;
      22: t = 36'sd163;
      23: t = 36'sd81;
      24: t = 36'sd41;
      25: t = 36'sd20;
      26: t = 36'sd10;
      27: t = 36'sd5;
      28: t = 36'sd3;
      29: t = 36'sd1;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Wrap to a 32-bit signed phase, sign-extended back to the datapath width.
  function automatic data_t wrap_phase(input data_t v);
    return data_t'(signed'(v[31:0]));
  endfunction

  // Q2.30 product, floored.
  function automatic data_t mulq(input data_t a, input data_t b);
    logic signed [2*DataWidth-1:0] p;
    p = a * b;
    return data_t'(p >>> 30);
  endfunction

endpackage

[rtl/eqma_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqma_stream_if: valid/ready channel carrying a pair of angles
// One word is two signed binary angles.
// ----------------------------------------------------------------------------
interface eqma_stream_if;
  import eqma_pkg::*;
  logic   valid;
  logic   ready;
  angle_t a;
  angle_t b;
  modport source (output valid, output a, output b, input ready);
  modport sink (input valid, input a, input b, output ready);
endinterface

[rtl/equatorial_to_mount_axes.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equatorial_to_mount_axes: hour angle / declination to mount axis angles
// Pipelined conversion built from rows of CORDIC cells.
// ----------------------------------------------------------------------------
// Usage: in_if carries a word of hour angle (a) and declination (b); out_if
// returns first axis (a) and second axis (b), one word per input word, in
// order. Latitude and mount kind are written through cfg_we_i/cfg_idx_i/
// cfg_data_i while the block is idle.
// Throughput: one word per cycle unless the receiver stalls. Latency is the
// same for every mount kind: the pipeline is a series of CORDIC rows
// (30 cells each) with registered multiply and fix-up stages between some
// of them; the alt-alt path sets the length.
// The whole pipe advances together; when the receiver stalls with the output
// register full, the pipe freezes and in_if.ready drops, so nothing is lost.
// Reset clears the valid flags and the registers (latitude 0, German
// equatorial); payload registers are not reset.
// ----------------------------------------------------------------------------
module equatorial_to_mount_axes import eqma_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  eqma_stream_if.sink            in_if,
  eqma_stream_if.source          out_if,
  input  logic                   cfg_we_i,
  input  logic [RegIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i
);

  localparam int Cl = Stages + 2;            // registers in one CORDIC row
  // Stage plan, in order from entry:
  //  T0 : regs of inputs
  //  row A (sin/cos h,d,l)
  //  M1 : products level 1
  //  M2 : products level 2
  //  M3 : sums
  //  row V1 atan2(t1,t2)
  //  row V2 atan2(sinalt,len)
  //  P  : az fix
  //  row B sin/cos(az,alt)
  //  M4 : u1, ca*cz
  //  row V3 atan2(u1,u2)
  //  row V4 atan2(cacz,len2)
  //  O  : output
  localparam int LatencyTotal = 1 + Cl + 3 + Cl + Cl + 1 + Cl + 1 + Cl + Cl + 1;

  angle_t lat_q;
  mount_kind_e kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q  <= '0;
      kind_q <= KIND_GERMAN;
    end else if (cfg_we_i) begin
      unique case (reg_index_e'(cfg_idx_i))
        REG_LATITUDE: lat_q  <= angle_t'(cfg_data_i);
        REG_KIND:     kind_q <= mount_kind_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // Global advance: pipe moves unless the output register holds an untaken
  // word.
  logic en;
  logic out_valid_q;
  logic vld_q [LatencyTotal];
  assign en = !out_valid_q || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LatencyTotal; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_if.valid;
      for (int i = 1; i < LatencyTotal; i++) vld_q[i] <= vld_q[i-1];
    end
  end
  assign out_valid_q = vld_q[LatencyTotal-1];

  // Raw angle delay line for pass-through kinds and the pole test.
  angle_t ha_dl [LatencyTotal];
  angle_t dec_dl [LatencyTotal];
  always_ff @(posedge clk_i) begin
    if (en) begin
      ha_dl[0]  <= in_if.a;
      dec_dl[0] <= in_if.b;
      for (int i = 1; i < LatencyTotal; i++) begin
        ha_dl[i]  <= ha_dl[i-1];
        dec_dl[i] <= dec_dl[i-1];
      end
    end
  end

  // Row A: three parallel sin/cos rows.
  data_t sh, ch, sd, cd, sl, cl;
  eqma_cordic_chain u_sc_h (.clk_i, .en_i(en), .mode_i(MODE_ROTATE),
    .a_i(data_t'(ha_dl[0])), .b_i('0), .r0_o(sh), .r1_o(ch));
  eqma_cordic_chain u_sc_d (.clk_i, .en_i(en), .mode_i(MODE_ROTATE),
    .a_i(data_t'(dec_dl[0])), .b_i('0), .r0_o(sd), .r1_o(cd));
  eqma_cordic_chain u_sc_l (.clk_i, .en_i(en), .mode_i(MODE_ROTATE),
    .a_i(data_t'(lat_q)), .b_i('0), .r0_o(sl), .r1_o(cl));

  // Multiply stages.
  data_t m_sdsl_q, m_cdcl_q, m_cdsh_q, m_cdch_q, m_sdcl_q, m_ch_q, m_sl_q;
  data_t m_t1_q, m_cdclch_q, m_cdchsl_q, m_sdsl2_q, m_sdcl2_q;
  data_t sinalt_q, t1_q, t2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_sdsl_q   <= mulq(sd, sl);
      m_cdcl_q   <= mulq(cd, cl);
      m_cdsh_q   <= mulq(cd, sh);
      m_cdch_q   <= mulq(cd, ch);
      m_sdcl_q   <= mulq(sd, cl);
      m_ch_q     <= ch;
      m_sl_q     <= sl;
      m_cdclch_q <= mulq(m_cdcl_q, m_ch_q);
      m_cdchsl_q <= mulq(m_cdch_q, m_sl_q);
      m_sdsl2_q  <= m_sdsl_q;
      m_sdcl2_q  <= m_sdcl_q;
      m_t1_q     <= m_cdsh_q;
      sinalt_q   <= m_sdsl2_q + m_cdclch_q;
      t1_q       <= m_t1_q;
      t2_q       <= m_cdchsl_q - m_sdcl2_q;
    end
  end

  // V1: azimuth; sin_alt delayed alongside.
  data_t az_raw, len1;
  eqma_cordic_chain u_v1 (.clk_i, .en_i(en), .mode_i(MODE_VECTOR),
    .a_i(t1_q), .b_i(t2_q), .r0_o(az_raw), .r1_o(len1));
  data_t sa_dl [Cl];
  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_dl[0] <= sinalt_q;
      for (int i = 1; i < Cl; i++) sa_dl[i] <= sa_dl[i-1];
    end
  end

  // V2: altitude; azimuth delayed alongside.
  data_t alt, unused_len;
  eqma_cordic_chain u_v2 (.clk_i, .en_i(en), .mode_i(MODE_VECTOR),
    .a_i(sa_dl[Cl-1]), .b_i(len1), .r0_o(alt), .r1_o(unused_len));
  data_t az_dl [Cl];
  always_ff @(posedge clk_i) begin
    if (en) begin
      az_dl[0] <= az_raw;
      for (int i = 1; i < Cl; i++) az_dl[i] <= az_dl[i-1];
    end
  end

  // Pole fix. Declination at this point sits at index PoleAt.
  localparam int PoleAt = 1 + Cl + 3 + Cl + Cl - 1;
  data_t dph, az_q, alt_q;
  always_comb dph = data_t'(dec_dl[PoleAt]);
  always_ff @(posedge clk_i) begin
    if (en) begin
      alt_q <= alt;
      if ((dph - Quarter <= PoleTol) && (dph - Quarter >= -PoleTol)) az_q <= '0;
      else if ((dph + Quarter <= PoleTol) && (dph + Quarter >= -PoleTol)) az_q <= -Half;
      else az_q <= wrap_phase(az_dl[Cl-1] + Half);
    end
  end

  // Row B.
  data_t sz, cz, sa, ca;
  eqma_cordic_chain u_sc_z (.clk_i, .en_i(en), .mode_i(MODE_ROTATE),
    .a_i(az_q), .b_i('0), .r0_o(sz), .r1_o(cz));
  eqma_cordic_chain u_sc_a (.clk_i, .en_i(en), .mode_i(MODE_ROTATE),
    .a_i(alt_q), .b_i('0), .r0_o(sa), .r1_o(ca));
  data_t azb_dl [Cl];
  data_t altb_dl [Cl];
  always_ff @(posedge clk_i) begin
    if (en) begin
      azb_dl[0]  <= az_q;
      altb_dl[0] <= alt_q;
      for (int i = 1; i < Cl; i++) begin
        azb_dl[i]  <= azb_dl[i-1];
        altb_dl[i] <= altb_dl[i-1];
      end
    end
  end

  data_t u1_q, u2_q, cacz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_q   <= mulq(ca, sz);
      u2_q   <= -sa;
      cacz_q <= mulq(ca, cz);
    end
  end

  // V3 and V4.
  data_t a1, len2, a2, unused_len2;
  eqma_cordic_chain u_v3 (.clk_i, .en_i(en), .mode_i(MODE_VECTOR),
    .a_i(u1_q), .b_i(u2_q), .r0_o(a1), .r1_o(len2));
  data_t cacz_dl [Cl];
  data_t az2_dl [2*Cl+1];
  data_t alt2_dl [2*Cl+1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      cacz_dl[0] <= cacz_q;
      for (int i = 1; i < Cl; i++) cacz_dl[i] <= cacz_dl[i-1];
      az2_dl[0]  <= azb_dl[Cl-1];
      alt2_dl[0] <= altb_dl[Cl-1];
      for (int i = 1; i < 2*Cl+1; i++) begin
        az2_dl[i]  <= az2_dl[i-1];
        alt2_dl[i] <= alt2_dl[i-1];
      end
    end
  end
  eqma_cordic_chain u_v4 (.clk_i, .en_i(en), .mode_i(MODE_VECTOR),
    .a_i(cacz_dl[Cl-1]), .b_i(len2), .r0_o(a2), .r1_o(unused_len2));
  data_t a1_dl [Cl];
  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_dl[0] <= wrap_phase(a1 + Half);
      for (int i = 1; i < Cl; i++) a1_dl[i] <= a1_dl[i-1];
    end
  end

  // Output register.
  angle_t o_a_q, o_b_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      unique case (kind_q)
        KIND_GERMAN, KIND_FORK: begin
          o_a_q <= ha_dl[LatencyTotal-2];
          o_b_q <= dec_dl[LatencyTotal-2];
        end
        KIND_ALTAZ: begin
          o_a_q <= angle_t'(az2_dl[2*Cl]);
          o_b_q <= angle_t'(alt2_dl[2*Cl]);
        end
        default: begin
          o_a_q <= angle_t'(a1_dl[Cl-1]);
          o_b_q <= angle_t'(a2);
        end
      endcase
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.a     = o_a_q;
  assign out_if.b     = o_b_q;

  // A stalled word must hold its place in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_if.ready |=> out_valid_q && $stable(o_a_q))
    else $error("output word lost under stall");
  // Input is taken exactly when the pipe advances.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready == (!out_valid_q || out_if.ready))
    else $error("ready out of step with pipe");
  // When the pipe advances, the word in the slot before the output moves up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[LatencyTotal-2] |=> out_valid_q)
    else $error("word dropped at the tail");

endmodule

[rtl/eqma_cordic_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqma_cordic_cell: one CORDIC micro-rotation with output register
// Rotation mode steers on z, vectoring mode on y. Stalls with the chain.
// ----------------------------------------------------------------------------
module eqma_cordic_cell import eqma_pkg::*; (
  input  logic         clk_i,
  input  logic         en_i,
  input  cordic_mode_e mode_i,
  input  logic [4:0]   shift_i,
  input  data_t        atan_i,
  input  data_t        x_i,
  input  data_t        y_i,
  input  data_t        z_i,
  output data_t        x_o,
  output data_t        y_o,
  output data_t        z_o
);

  data_t x_d, y_d, z_d, x_q, y_q, z_q, xs, ys;
  logic  up;

  always_comb begin
    xs = x_i >>> shift_i;
    ys = y_i >>> shift_i;
    up = (mode_i == MODE_ROTATE) ? !z_i[DataWidth-1] : !y_i[DataWidth-1];
    if (mode_i == MODE_ROTATE) begin
      x_d = up ? x_i - ys : x_i + ys;
      y_d = up ? y_i + xs : y_i - xs;
    end else begin
      x_d = up ? x_i + ys : x_i - ys;
      y_d = up ? y_i - xs : y_i + xs;
    end
    z_d = up ? z_i - atan_i : z_i + atan_i;
    if (mode_i == MODE_VECTOR) z_d = up ? z_i + atan_i : z_i - atan_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

[rtl/eqma_cordic_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqma_cordic_chain: row of CORDIC cells, one result per cycle while enabled
// Rotation: z in, sin/cos out (folded). Vectoring: atan2 and scaled length.
// Registers: pre-fold, Stages cells, output; a fold flag travels alongside.
// ----------------------------------------------------------------------------
module eqma_cordic_chain import eqma_pkg::*; (
  input  logic         clk_i,
  input  logic         en_i,
  input  cordic_mode_e mode_i,
  input  data_t        a_i,     // rotate: phase; vector: y
  input  data_t        b_i,     // vector: x
  output data_t        r0_o,    // rotate: sin; vector: angle
  output data_t        r1_o     // rotate: cos; vector: length
);

  data_t x0_q, y0_q, z0_q;
  logic  neg0_q;
  logic  neg_q [Stages];
  data_t xc [Stages+1];
  data_t yc [Stages+1];
  data_t zc [Stages+1];
  data_t r0_q, r1_q, px, py, pz;
  logic  pneg;
  logic signed [2*DataWidth-1:0] mag;

  // Pre-fold ahead of the row.
  always_comb begin
    pneg = 1'b0;
    px = '0;
    py = '0;
    pz = '0;
    if (mode_i == MODE_ROTATE) begin
      px = GainComp;
      pz = a_i;
      if (a_i > Quarter) begin
        pz = a_i - Half;
        pneg = 1'b1;
      end else if (a_i < -Quarter) begin
        pz = a_i + Half;
        pneg = 1'b1;
      end
    end else begin
      px = b_i;
      py = a_i;
      if (b_i[DataWidth-1]) begin
        px = -b_i;
        py = -a_i;
        pz = Half;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q   <= px;
      y0_q   <= py;
      z0_q   <= pz;
      neg0_q <= pneg;
    end
  end

  assign xc[0] = x0_q;
  assign yc[0] = y0_q;
  assign zc[0] = z0_q;

  for (genvar g = 0; g < Stages; g++) begin : g_cell
    eqma_cordic_cell u_cell (
      .clk_i,
      .en_i,
      .mode_i,
      .shift_i (5'(g)),
      .atan_i  (atan_entry(g)),
      .x_i     (xc[g]),
      .y_i     (yc[g]),
      .z_i     (zc[g]),
      .x_o     (xc[g+1]),
      .y_o     (yc[g+1]),
      .z_o     (zc[g+1])
    );
    if (g == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i) neg_q[g] <= neg0_q;
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i) neg_q[g] <= neg_q[g-1];
      end
    end
  end

  assign mag = xc[Stages] * GainComp;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (mode_i == MODE_ROTATE) begin
        r0_q <= neg_q[Stages-1] ? -yc[Stages] : yc[Stages];
        r1_q <= neg_q[Stages-1] ? -xc[Stages] : xc[Stages];
      end else begin
        r0_q <= wrap_phase(zc[Stages]);
        r1_q <= data_t'(mag >>> 30);
      end
    end
  end

  assign r0_o = r0_q;
  assign r1_o = r1_q;

endmodule

[tb/eqma_axes_scoreboard.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqma_axes_scoreboard: predicted mount axis words and their comparison
// Computes the expected axis angles of each accepted input word from the
// current latitude and mount kind, queues them, and compares result words
// in order.
// ----------------------------------------------------------------------------
package eqma_axes_sb_pkg;
  import eqma_pkg::*;

  typedef logic signed [63:0] wide_t;

  typedef struct packed {
    angle_t first_axis;
    angle_t second_axis;
  } axes_t;

  localparam wide_t GainQ   = 64'sd652032874;
  localparam wide_t QuarterQ = 64'sd1073741824;
  localparam wide_t HalfQ   = 64'sd2147483648;
  localparam wide_t PoleBand = 64'sd331;

  function automatic wide_t arc_step(input int i);
    case (i)
      0: return 536870912;  1: return 316933406;  2: return 167458907;
      3: return 85004756;   4: return 42667331;   5: return 21354465;
      6: return 10679838;   7: return 5340245;    8: return 2670163;
      9: return 1335087;    10: return 667544;    11: return 333772;
      12: return 166886;    13: return 83443;     14: return 41722;
      15: return 20861;     16: return 10430;     17: return 5215;
      18: return 2608;      19: return 1304;      20: return 652;
      21: return 326;       22: return 163;       23: return 81;
      24: return 41;        25: return 20;        26: return 10;
      27: return 5;         28: return 3;         29: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic wide_t fold32(input wide_t v);
    logic signed [31:0] t;
    t = v[31:0];
    return wide_t'(t);
  endfunction

  function automatic wide_t qprod(input wide_t a, input wide_t b);
    wide_t p;
    p = a * b;
    return p >>> 30;
  endfunction

  task automatic sin_cos(input wide_t ph, output wide_t s, output wide_t c);
    bit flip;
    wide_t x, y, z, t;
    flip = 0;
    x = GainQ;
    y = 0;
    if (ph > QuarterQ) begin
      ph = ph - HalfQ;
      flip = 1;
    end else if (ph < -QuarterQ) begin
      ph = ph + HalfQ;
      flip = 1;
    end
    z = ph;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - arc_step(i);
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + arc_step(i);
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endtask

  task automatic arc_tan2(input wide_t y, input wide_t x, output wide_t ang,
                          output wide_t len);
    wide_t z, t;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HalfQ;
    end
    for (int i = 0; i < 30; i++) begin
      if (y >= 0) begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + arc_step(i);
      end else begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - arc_step(i);
      end
      x = t;
    end
    len = qprod(x, GainQ);
    ang = fold32(z);
  endtask

  class axes_scoreboard;
    angle_t      latitude;
    mount_kind_e kind;
    axes_t       pending[$];
    int          mismatches;

    function new();
      latitude = '0;
      kind = KIND_GERMAN;
      mismatches = 0;
    endfunction

    task automatic predict(input angle_t ha, input angle_t dec, output axes_t r);
      wide_t h, d, l, sh, ch, sd, cd, sl, cl, sin_alt, t1, t2, len, spare;
      wide_t az, alt, dd, sz, cz, sa, ca, u1, u2, a1, a2, len2;
      if (kind == KIND_GERMAN || kind == KIND_FORK) begin
        r.first_axis = ha;
        r.second_axis = dec;
        return;
      end
      h = ha;
      d = dec;
      l = latitude;
      sin_cos(h, sh, ch);
      sin_cos(d, sd, cd);
      sin_cos(l, sl, cl);
      sin_alt = qprod(sd, sl) + qprod(qprod(cd, cl), ch);
      t1 = qprod(cd, sh);
      t2 = qprod(qprod(cd, ch), sl) - qprod(sd, cl);
      arc_tan2(t1, t2, az, len);
      arc_tan2(sin_alt, len, alt, spare);
      dd = d - QuarterQ;
      if (dd <= PoleBand && dd >= -PoleBand) az = 0;
      else begin
        dd = d + QuarterQ;
        if (dd <= PoleBand && dd >= -PoleBand) az = -HalfQ;
        else az = fold32(az + HalfQ);
      end
      if (kind == KIND_ALTAZ) begin
        r.first_axis = az[31:0];
        r.second_axis = alt[31:0];
        return;
      end
      sin_cos(az, sz, cz);
      sin_cos(alt, sa, ca);
      u1 = qprod(ca, sz);
      u2 = -sa;
      arc_tan2(u1, u2, a1, len2);
      arc_tan2(qprod(ca, cz), len2, a2, spare);
      a1 = fold32(a1 + HalfQ);
      r.first_axis = a1[31:0];
      r.second_axis = a2[31:0];
    endtask

    task automatic note_input(input angle_t ha, input angle_t dec);
      axes_t r;
      predict(ha, dec, r);
      pending.push_back(r);
    endtask

    function void check_result(input angle_t first_axis, input angle_t second_axis);
      axes_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: %0d %0d", first_axis, second_axis);
        return;
      end
      e = pending.pop_front();
      if (e.first_axis !== first_axis || e.second_axis !== second_axis) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %0d %0d got %0d %0d", e.first_axis,
                   e.second_axis, first_axis, second_axis);
      end
    endfunction
  endclass
endpackage

[tb/tb_equatorial_to_mount_axes.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_equatorial_to_mount_axes: mount axis conversion testbench
// Directed and random angle words across all mount kinds and six latitudes,
// random idling on both sides but in the last phases, results checked in order against a predictor.
// ----------------------------------------------------------------------------
module tb_equatorial_to_mount_axes;
  import eqma_pkg::*;
  import eqma_axes_sb_pkg::*;

  localparam int Latency = 260;
  localparam longint CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [RegIdxWidth-1:0] cfg_idx_i = '0;
  logic [CfgWidth-1:0] cfg_data_i = '0;
  bit calm = 0;
  longint cycles = 0;

  eqma_stream_if in_if ();
  eqma_stream_if out_if ();

  equatorial_to_mount_axes dut (
    .clk_i, .rst_ni, .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  axes_scoreboard board = new();

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.a = '0;
    in_if.b = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_equatorial_to_mount_axes failed");
      $finish;
    end
    if (rst_ni && in_if.valid && in_if.ready) board.note_input(in_if.a, in_if.b);
    if (rst_ni && out_if.valid && out_if.ready) board.check_result(out_if.a, out_if.b);
  end

  // receiver stalls in bursts
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        out_if.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_word(input angle_t ha, input angle_t dec);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.a <= ha;
    in_if.b <= dec;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);
  endtask

  // write enable stays high; the caller drops it after the last register
  task automatic write_reg(input reg_index_e idx, input logic [CfgWidth-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
  endtask

  task automatic set_mode(input angle_t lat, input mount_kind_e k);
    drain();
    write_reg(REG_LATITUDE, lat);
    write_reg(REG_KIND, CfgWidth'(k));
    cfg_we_i <= 1'b0;
    board.latitude = lat;
    board.kind = k;
  endtask

  function automatic angle_t rand_dec();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return angle_t'(32'sd1073741824 - $signed($urandom_range(0, 700)));
    if (r == 1) return angle_t'(-32'sd1073741824 + $signed($urandom_range(0, 700)));
    if (r == 2) return angle_t'($urandom());
    return angle_t'($signed($urandom_range(0, 32'h7fffffff)) - 32'sd1073741824);
  endfunction

  initial begin
    angle_t lats[6];
    mount_kind_e k;
    lats = '{32'sd0, 32'sd1073741824, -32'sd1073741824, 32'sd536870912,
             -32'sd400000000, 32'sd123456789};
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // directed: extremes and pole cases, every kind
    for (int m = 0; m < 4; m++) begin
      k = mount_kind_e'(m);
      set_mode(m[0] ? 32'sd536870912 : 32'sd0, k);
      send_word(32'sh80000000, 32'sd1073741824);
      send_word(32'sh7fffffff, -32'sd1073741824);
      send_word(32'sd0, 32'sd1073741824 - 32'sd331);
      send_word(32'sd0, -32'sd1073741824 + 32'sd332);
      send_word(32'sd0, 32'sd0);
      send_word(32'hffffffff, 32'h7fffffff);
    end
    // pause until every result is in
    drain();
    for (int ph = 0; ph < 24; ph++) begin
      set_mode(lats[ph % 6], mount_kind_e'(ph % 4));
      if (ph == 21) calm = 1;
      repeat (60) send_word(angle_t'($urandom()), rand_dec());
    end
    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("tb_equatorial_to_mount_axes passed");
    else
      $display("tb_equatorial_to_mount_axes failed");
    $finish;
  end
endmodule
